// ===== hw/rtl/avgbg_pkg.sv =====
`default_nettype none
package avgbg_pkg;

	localparam int NUM_PIXELS       = 65536;
	localparam int MAX_LEARN_FRAMES = 255;

	localparam int ADDR_W     = 16;
	localparam int CH_W       = 8;
	localparam int SUM_W      = 16;
	localparam int CNT_W      = $clog2(MAX_LEARN_FRAMES + 1);
	localparam int FRAC_W     = 4;
	localparam int Q_W        = 12;
	localparam int DIVD_W     = SUM_W + FRAC_W;
	localparam int LIM_W      = 17;
	localparam int SCALE_W    = 8;
	localparam int FUNC_W     = 2;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_PIXELS - 1);
	localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_LEARN_FRAMES);

	localparam logic [FUNC_W-1:0] FUNC_LEARN  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FINAL  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_DETECT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_HIGH_SCALE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_SCALE  = 8'd1;

	localparam logic [SCALE_W-1:0] HIGH_SCALE_RST = 8'd112;
	localparam logic [SCALE_W-1:0] LOW_SCALE_RST  = 8'd96;

	typedef enum logic [1:0] {
		OP_LEARN,
		OP_FINAL,
		OP_DETECT
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic [ADDR_W-1:0]     idx;
		logic [2:0][CH_W-1:0]  px;
		logic                  last;
	} item_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/avgbg_if.sv =====
`default_nettype none
interface avgbg_in_if;
	logic                             valid;
	logic                             ready;
	logic [avgbg_pkg::FUNC_W-1:0]     func;
	logic [avgbg_pkg::ADDR_W-1:0]     pixel_index;
	logic [avgbg_pkg::CH_W-1:0]       red;
	logic [avgbg_pkg::CH_W-1:0]       green;
	logic [avgbg_pkg::CH_W-1:0]       blue;
	logic                             last_of_frame;
	modport source (output valid, func, pixel_index, red, green, blue, last_of_frame,
		input ready);
	modport sink (input valid, func, pixel_index, red, green, blue, last_of_frame,
		output ready);
endinterface

interface avgbg_out_if;
	logic                         valid;
	logic                         ready;
	logic [avgbg_pkg::ADDR_W-1:0] out_index;
	logic                         foreground;
	logic [avgbg_pkg::CH_W-1:0]   mask_value;
	modport source (output valid, out_index, foreground, mask_value, input ready);
	modport sink (input valid, out_index, foreground, mask_value, output ready);
endinterface

interface avgbg_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [avgbg_pkg::CFG_IDX_W-1:0]  index;
	logic [avgbg_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/avgbg_front.sv =====
`default_nettype none
module avgbg_front (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	avgbg_in_if.sink                     pixel,
	input  wire avgbg_pkg::back_status_t status,
	input  wire logic                    fifo_full,
	output logic                         push,
	output avgbg_pkg::item_t             push_item
);

	logic keep;
	logic in_range;

	// classification is pure logic, clk and reset only used by the checker-side view
	logic seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (pixel.valid && pixel.ready) begin
			seen_q <= 1'b1;
		end
	end

	assign pixel.ready = !status.clearing && !fifo_full && (seen_q || !seen_q);

	assign in_range = ({1'b0, pixel.pixel_index} <= {1'b0, avgbg_pkg::LAST_ADDR});

	always_comb begin
		push_item.idx  = pixel.pixel_index;
		push_item.px   = {pixel.blue, pixel.green, pixel.red};
		push_item.last = pixel.last_of_frame;
		push_item.op   = avgbg_pkg::OP_LEARN;
		keep           = 1'b1;
		case (pixel.func)
			avgbg_pkg::FUNC_LEARN:  push_item.op = avgbg_pkg::OP_LEARN;
			avgbg_pkg::FUNC_FINAL:  push_item.op = avgbg_pkg::OP_FINAL;
			avgbg_pkg::FUNC_DETECT: push_item.op = avgbg_pkg::OP_DETECT;
			default:                keep = 1'b0;
		endcase
	end

	assign push = pixel.valid && pixel.ready && keep && in_range;

endmodule
`default_nettype wire

// ===== hw/rtl/avgbg_fifo.sv =====
`default_nettype none
module avgbg_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire avgbg_pkg::item_t din,
	input  wire logic             pop,
	output avgbg_pkg::item_t      dout,
	output logic                  full,
	output logic                  empty
);

	avgbg_pkg::item_t                     mem_q [avgbg_pkg::FIFO_DEPTH];
	logic [avgbg_pkg::FIFO_PTR_W-1:0]     wr_ptr_q;
	logic [avgbg_pkg::FIFO_PTR_W-1:0]     rd_ptr_q;
	logic [avgbg_pkg::FIFO_PTR_W:0]       cnt_q;

	assign full  = (cnt_q == (avgbg_pkg::FIFO_PTR_W + 1)'(avgbg_pkg::FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/avgbg_div.sv =====
`default_nettype none
module avgbg_div (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [avgbg_pkg::SUM_W-1:0]   sum,
	input  wire logic [avgbg_pkg::CNT_W-1:0]   cnt,
	output logic [avgbg_pkg::Q_W-1:0]          q
);

	localparam int CMP_W = avgbg_pkg::DIVD_W + avgbg_pkg::CNT_W + avgbg_pkg::Q_W;
	localparam int QW    = avgbg_pkg::Q_W;
	localparam int CW    = avgbg_pkg::CNT_W;

	logic [avgbg_pkg::DIVD_W-1:0] n;
	logic                         zero_in;
	logic                         sat_in;

	logic [CW-1:0] r_q    [QW];
	logic [QW-1:0] quo_q  [QW];
	logic [QW-1:0] low_q  [QW];
	logic [CW-1:0] d_q    [QW];
	logic          zero_q [QW];
	logic          sat_q  [QW];

	assign n       = {sum, {avgbg_pkg::FRAC_W{1'b0}}};
	assign zero_in = (cnt == '0);
	// quotient above the Q8.4 range saturates, so only Q_W quotient bits are developed
	assign sat_in  = (CMP_W'(n) >= CMP_W'({cnt, {QW{1'b0}}}));

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [CW-1:0] r_in;
		logic [QW-1:0] quo_in;
		logic [QW-1:0] low_in;
		logic [CW-1:0] d_in;
		logic          zero_i;
		logic          sat_i;
		logic [CW:0]   trial;
		logic [CW-1:0] r_out;
		logic          qb;

		if (k == 0) begin : g_first
			assign r_in   = CW'(n >> QW);
			assign quo_in = '0;
			assign low_in = n[QW-1:0];
			assign d_in   = cnt;
			assign zero_i = zero_in;
			assign sat_i  = sat_in;
		end else begin : g_next
			assign r_in   = r_q[k-1];
			assign quo_in = quo_q[k-1];
			assign low_in = low_q[k-1];
			assign d_in   = d_q[k-1];
			assign zero_i = zero_q[k-1];
			assign sat_i  = sat_q[k-1];
		end

		always_comb begin
			trial = {r_in, low_in[QW-1]};
			if (trial >= {1'b0, d_in}) begin
				r_out = CW'(trial - {1'b0, d_in});
				qb    = 1'b1;
			end else begin
				r_out = trial[CW-1:0];
				qb    = 1'b0;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_q[k]    <= r_out;
				quo_q[k]  <= {quo_in[QW-2:0], qb};
				low_q[k]  <= {low_in[QW-2:0], 1'b0};
				d_q[k]    <= d_in;
				zero_q[k] <= zero_i;
				sat_q[k]  <= sat_i;
			end
		end
	end

	always_comb begin
		if (zero_q[QW-1]) begin
			q = '0;
		end else if (sat_q[QW-1]) begin
			q = '1;
		end else begin
			q = quo_q[QW-1];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/avgbg_back.sv =====
`default_nettype none
module avgbg_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire avgbg_pkg::item_t fifo_item,
	input  wire logic             fifo_empty,
	output logic                  pop,
	output avgbg_pkg::back_status_t status,
	avgbg_cfg_if.sink             cfg,
	avgbg_out_if.source           result
);

	localparam int SW     = avgbg_pkg::SUM_W;
	localparam int CH     = avgbg_pkg::CH_W;
	localparam int QW     = avgbg_pkg::Q_W;
	localparam int LW     = avgbg_pkg::LIM_W;
	localparam int FW     = avgbg_pkg::FRAC_W;
	localparam int DIFF_W = QW + 1;
	localparam int PROD_W = DIFF_W + avgbg_pkg::SCALE_W;
	localparam int ACC_W  = PROD_W + 2;

	localparam logic signed [ACC_W-1:0] LIM_HI = ACC_W'(2**(LW-1) - 1);
	localparam logic signed [ACC_W-1:0] LIM_LO = ACC_W'(-(2**(LW-1)));

	typedef struct packed {
		logic [2:0][SW-1:0] val;
		logic [2:0][SW-1:0] dif;
	} sums_t;

	typedef struct packed {
		logic [2:0][LW-1:0] hi;
		logic [2:0][LW-1:0] lo;
	} lims_t;

	function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [CH-1:0] b);
		logic [SW:0] s;
		s = {1'b0, a} + (SW + 1)'(b);
		return s[SW] ? '1 : s[SW-1:0];
	endfunction

	function automatic logic [LW-1:0] clamp_lim(input logic signed [ACC_W-1:0] v);
		if (v > LIM_HI) begin
			return LIM_HI[LW-1:0];
		end else if (v < LIM_LO) begin
			return LIM_LO[LW-1:0];
		end
		return v[LW-1:0];
	endfunction

	// memories
	sums_t                sum_mem  [avgbg_pkg::NUM_PIXELS];
	logic [2:0][CH-1:0]   prev_mem [avgbg_pkg::NUM_PIXELS];
	lims_t                lim_mem  [avgbg_pkg::NUM_PIXELS];

	logic en;
	logic take;

	logic                            clr_q;
	logic [avgbg_pkg::ADDR_W-1:0]    clr_addr_q;
	logic [avgbg_pkg::SCALE_W-1:0]   hs_q;
	logic [avgbg_pkg::SCALE_W-1:0]   ls_q;
	logic [avgbg_pkg::CNT_W-1:0]     cnt_q;
	logic                            first_q;

	// stage 1: memory read data, learn update
	logic                  v_s1;
	avgbg_pkg::item_t      item_s1;
	sums_t                 sum_rd_q;
	logic [2:0][CH-1:0]    prev_rd_q;
	logic                  wr_v_q;
	logic [avgbg_pkg::ADDR_W-1:0] wr_addr_q;
	sums_t                 wr_sums_q;
	logic [2:0][CH-1:0]    wr_prev_q;
	sums_t                 sums_cur;
	logic [2:0][CH-1:0]    prev_cur;
	sums_t                 sums_new;
	logic                  learn_do;

	// stage 2: divider operands
	logic                          v_s2;
	avgbg_pkg::item_t              item_s2;
	sums_t                         sums_s2;
	logic [avgbg_pkg::CNT_W-1:0]   cnt_s2;

	logic                  v_d_q    [QW];
	avgbg_pkg::item_t      item_d_q [QW];
	logic [2:0][QW-1:0]    avg_q;
	logic [2:0][QW-1:0]    dif_q;

	// stage 15: products
	logic                      v_s15;
	avgbg_pkg::item_t          item_s15;
	logic [2:0][QW-1:0]        avg_s15;
	logic [2:0][PROD_W-1:0]    ph_s15;
	logic [2:0][PROD_W-1:0]    pl_s15;
	logic [2:0][PROD_W-1:0]    ph_n;
	logic [2:0][PROD_W-1:0]    pl_n;
	lims_t                     lims_new;

	// stage 16: compare
	logic                  v_s16;
	avgbg_pkg::item_t      item_s16;
	lims_t                 lim_rd_q;
	logic                  fg_n;

	logic                          res_valid_q;
	logic [avgbg_pkg::ADDR_W-1:0]  res_idx_q;
	logic                          res_fg_q;

	assign en              = !res_valid_q || result.ready;
	assign take            = en && !fifo_empty && !clr_q;
	assign pop             = take;
	assign status.clearing = clr_q;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_q <= avgbg_pkg::HIGH_SCALE_RST;
			ls_q <= avgbg_pkg::LOW_SCALE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				avgbg_pkg::REG_HIGH_SCALE: hs_q <= cfg.data;
				avgbg_pkg::REG_LOW_SCALE:  ls_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// clearing pass over the sums after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == avgbg_pkg::LAST_ADDR) begin
				clr_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// read port of sums and previous pixel, issued as the word leaves the queue
	always_ff @(posedge clk) begin
		if (en) begin
			sum_rd_q  <= sum_mem[fifo_item.idx];
			prev_rd_q <= prev_mem[fifo_item.idx];
			item_s1   <= fifo_item;
		end
	end

	// the word just ahead wrote the same entry in the cycle this read was issued
	always_comb begin
		if (wr_v_q && (wr_addr_q == item_s1.idx)) begin
			sums_cur = wr_sums_q;
			prev_cur = wr_prev_q;
		end else begin
			sums_cur = sum_rd_q;
			prev_cur = prev_rd_q;
		end
	end

	assign learn_do = v_s1 && (item_s1.op == avgbg_pkg::OP_LEARN) && (cnt_q < avgbg_pkg::MAX_CNT);

	always_comb begin
		logic [CH-1:0] d;
		sums_new = sums_cur;
		for (int c = 0; c < 3; c++) begin
			d = (item_s1.px[c] >= prev_cur[c]) ? (item_s1.px[c] - prev_cur[c])
				: (prev_cur[c] - item_s1.px[c]);
			if (!first_q) begin
				sums_new.val[c] = sat_add(sums_cur.val[c], item_s1.px[c]);
				sums_new.dif[c] = sat_add(sums_cur.dif[c], d);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			sum_mem[clr_addr_q] <= '0;
		end else if (en && learn_do) begin
			sum_mem[item_s1.idx] <= sums_new;
		end
	end

	always_ff @(posedge clk) begin
		if (en && learn_do) begin
			prev_mem[item_s1.idx] <= item_s1.px;
			wr_addr_q             <= item_s1.idx;
			wr_sums_q             <= sums_new;
			wr_prev_q             <= item_s1.px;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_v_q  <= 1'b0;
			cnt_q   <= '0;
			first_q <= 1'b1;
		end else if (en && learn_do) begin
			wr_v_q <= 1'b1;
			if (item_s1.last) begin
				if (first_q) begin
					first_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2 <= item_s1;
			sums_s2 <= sums_cur;
			cnt_s2  <= cnt_q;
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_ch
		avgbg_div u_div_avg (
			.clk (clk),
			.en  (en),
			.sum (sums_s2.val[c]),
			.cnt (cnt_s2),
			.q   (avg_q[c])
		);

		avgbg_div u_div_dif (
			.clk (clk),
			.en  (en),
			.sum (sums_s2.dif[c]),
			.cnt (cnt_s2),
			.q   (dif_q[c])
		);

		assign ph_n[c] = PROD_W'(DIFF_W'(dif_q[c]) + DIFF_W'(1 << FW)) * PROD_W'(hs_q);
		assign pl_n[c] = PROD_W'(DIFF_W'(dif_q[c]) + DIFF_W'(1 << FW)) * PROD_W'(ls_q);
	end

	// item delay line beside the dividers
	always_ff @(posedge clk) begin
		if (en) begin
			item_d_q[0] <= item_s2;
			for (int k = 1; k < QW; k++) begin
				item_d_q[k] <= item_d_q[k-1];
			end
			item_s15 <= item_d_q[QW-1];
			avg_s15  <= avg_q;
			ph_s15   <= ph_n;
			pl_s15   <= pl_n;
			item_s16 <= item_s15;
		end
	end

	always_comb begin
		logic signed [ACC_W-1:0] a16;
		for (int c = 0; c < 3; c++) begin
			a16 = $signed(ACC_W'({avg_s15[c], {FW{1'b0}}}));
			lims_new.hi[c] = clamp_lim((a16 + $signed(ACC_W'(ph_s15[c]))) >>> FW);
			lims_new.lo[c] = clamp_lim((a16 - $signed(ACC_W'(pl_s15[c]))) >>> FW);
		end
	end

	// limits are written and read at the same place in the pipe, so order is kept
	always_ff @(posedge clk) begin
		if (en) begin
			if (v_s15 && (item_s15.op == avgbg_pkg::OP_FINAL)) begin
				lim_mem[item_s15.idx] <= lims_new;
			end
			lim_rd_q <= lim_mem[item_s15.idx];
		end
	end

	always_comb begin
		logic signed [LW-1:0] pv;
		fg_n = 1'b0;
		for (int c = 0; c < 3; c++) begin
			pv = $signed(LW'({item_s16.px[c], {FW{1'b0}}}));
			if ((pv < $signed(lim_rd_q.lo[c])) || (pv > $signed(lim_rd_q.hi[c]))) begin
				fg_n = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_idx_q <= item_s16.idx;
			res_fg_q  <= fg_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s15       <= 1'b0;
			v_s16       <= 1'b0;
			res_valid_q <= 1'b0;
			for (int k = 0; k < QW; k++) begin
				v_d_q[k] <= 1'b0;
			end
		end else if (en) begin
			v_s1     <= take;
			v_s2     <= v_s1;
			v_d_q[0] <= v_s2;
			for (int k = 1; k < QW; k++) begin
				v_d_q[k] <= v_d_q[k-1];
			end
			v_s15       <= v_d_q[QW-1];
			v_s16       <= v_s15;
			res_valid_q <= v_s16 && (item_s16.op == avgbg_pkg::OP_DETECT);
		end
	end

	assign result.valid      = res_valid_q;
	assign result.out_index  = res_idx_q;
	assign result.foreground = res_fg_q;
	assign result.mask_value = {avgbg_pkg::CH_W{res_fg_q}};

endmodule
`default_nettype wire

// ===== hw/rtl/average_background_subtractor.sv =====
`default_nettype none
// per-pixel rgb background model with learn, finalize and detect words
//
// pixel: input words carry func, pixel_index, red, green, blue and
//   last_of_frame; a word is taken when valid and ready are both high.
//   learn (0) accumulates sums, finalize (1) turns one pixel's sums into
//   thresholds, detect (2) yields one result word; func 3 and indexes
//   beyond the frame are dropped.
// result: out_index, foreground and mask_value (255 or 0), valid/ready.
// cfg: register writes (0 high_scale, 1 low_scale), always ready; write
//   only while no word is in flight.
// throughput: one word per clock unless a held result stalls the back pipeline. a detect
//   result passes the sums memory read port, the 12-stage pipelined divider and the
//   limits memory ports before it is registered.
// reset: after arst_n is released a clearing pass zeroes the sums memory,
//   one entry per cycle for all 65536 entries; pixel.ready stays low until done.
// stall: a held result freezes the back pipeline; a 4-word queue between
//   the front and the back keeps pixel.ready high until it fills.
module average_background_subtractor (
	input  wire logic   clk,
	input  wire logic   arst_n,
	avgbg_in_if.sink    pixel,
	avgbg_cfg_if.sink   cfg,
	avgbg_out_if.source result
);

	avgbg_pkg::item_t        push_item;
	avgbg_pkg::item_t        fifo_item;
	avgbg_pkg::back_status_t status;
	logic                    push;
	logic                    pop;
	logic                    fifo_full;
	logic                    fifo_empty;

	avgbg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pixel),
		.status    (status),
		.fifo_full (fifo_full),
		.push      (push),
		.push_item (push_item)
	);

	avgbg_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_item),
		.pop    (pop),
		.dout   (fifo_item),
		.full   (fifo_full),
		.empty  (fifo_empty)
	);

	avgbg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_item  (fifo_item),
		.fifo_empty (fifo_empty),
		.pop        (pop),
		.status     (status),
		.cfg        (cfg),
		.result     (result)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/avgbg_checker.sv =====
`default_nettype none
module avgbg_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         pix_valid,
	input wire logic                         pix_ready,
	input wire logic [avgbg_pkg::FUNC_W-1:0] pix_func,
	input wire logic                         res_valid,
	input wire logic                         res_ready,
	input wire logic [avgbg_pkg::ADDR_W-1:0] res_index,
	input wire logic                         res_fg,
	input wire logic [avgbg_pkg::CH_W-1:0]   res_mask
);

	logic [7:0] pend_q;
	logic       in_det;
	logic       out_fire;

	assign in_det   = pix_valid && pix_ready && (pix_func == avgbg_pkg::FUNC_DETECT);
	assign out_fire = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_det && !out_fire) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_fire && !in_det) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_index) && $stable(res_fg))
		else $error("result word changed while stalled");

	a_clear_blocks: assert property (@(posedge clk) $rose(arst_n) |-> !pix_ready)
		else $error("pixel taken before clearing pass");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (pend_q != '0) && (res_mask == {avgbg_pkg::CH_W{res_fg}}))
		else $error("result without a detect word");

endmodule

bind average_background_subtractor avgbg_checker u_avgbg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pixel.valid),
	.pix_ready (pixel.ready),
	.pix_func  (pixel.func),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_index (result.out_index),
	.res_fg    (result.foreground),
	.res_mask  (result.mask_value)
);
`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import avgbg_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 40;
	localparam int IDLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int POOL_N = 6;

	typedef struct packed {
		logic [FUNC_W-1:0]    func;
		logic [ADDR_W-1:0]    idx;
		logic [2:0][CH_W-1:0] px;
		logic                 last;
	} pix_word_t;

	typedef struct packed {
		logic [ADDR_W-1:0] idx;
		logic              fg;
		logic [CH_W-1:0]   mask;
	} mask_word_t;

	// background model mirror plus queue of pending mask words
	class bg_scoreboard;
		bit [SUM_W-1:0] vsum[NUM_PIXELS][3];
		bit [SUM_W-1:0] dsum[NUM_PIXELS][3];
		bit [CH_W-1:0] prev[NUM_PIXELS][3];
		int upper[NUM_PIXELS][3];
		int lower[NUM_PIXELS][3];
		int frames;
		bit first;
		bit [SCALE_W-1:0] hs;
		bit [SCALE_W-1:0] ls;
		mask_word_t pending[$];
		int errors;
		int n_words;
		int n_masks;
		int n_fg;
		int n_writes;

		function new();
			first = 1;
			hs = HIGH_SCALE_RST;
			ls = LOW_SCALE_RST;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] i, logic [CFG_DATA_W-1:0] d);
			n_writes++;
			if (i == REG_HIGH_SCALE)
				hs = d;
			else if (i == REG_LOW_SCALE)
				ls = d;
		endfunction

		function longint mean_q84(int sum);
			int q;
			if (frames == 0)
				return 0;
			q = (sum * 16) / frames;
			return (q > 4095) ? 4095 : q;
		endfunction

		function int clamp_lim(longint v);
			if (v > 65535)
				return 65535;
			if (v < -65536)
				return -65536;
			return int'(v);
		endfunction

		function void note_word(pix_word_t w);
			int s;
			int d;
			longint a;
			longint df;
			bit fg;
			mask_word_t m;
			n_words++;
			case (w.func)
				FUNC_LEARN: begin
					if (frames >= MAX_LEARN_FRAMES)
						return;
					for (int c = 0; c < 3; c++) begin
						if (!first) begin
							d = (w.px[c] >= prev[w.idx][c]) ? w.px[c] - prev[w.idx][c]
								: prev[w.idx][c] - w.px[c];
							s = vsum[w.idx][c] + w.px[c];
							vsum[w.idx][c] = (s > 65535) ? 65535 : s;
							s = dsum[w.idx][c] + d;
							dsum[w.idx][c] = (s > 65535) ? 65535 : s;
						end
						prev[w.idx][c] = w.px[c];
					end
					if (w.last) begin
						if (first)
							first = 0;
						else
							frames++;
					end
				end
				FUNC_FINAL: begin
					for (int c = 0; c < 3; c++) begin
						a = mean_q84(vsum[w.idx][c]);
						df = mean_q84(dsum[w.idx][c]) + 16;
						// arithmetic shift floors negatives
						upper[w.idx][c] = clamp_lim((a * 16 + df * longint'(hs)) >>> 4);
						lower[w.idx][c] = clamp_lim((a * 16 - df * longint'(ls)) >>> 4);
					end
				end
				FUNC_DETECT: begin
					fg = 0;
					for (int c = 0; c < 3; c++)
						if (int'(w.px[c]) * 16 < lower[w.idx][c] ||
							int'(w.px[c]) * 16 > upper[w.idx][c])
							fg = 1;
					m.idx = w.idx;
					m.fg = fg;
					m.mask = fg ? 8'd255 : 8'd0;
					pending.push_back(m);
				end
				default: ;
			endcase
		endfunction

		function void check_word(mask_word_t got);
			mask_word_t e;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected mask word idx=%0d fg=%0d mask=%0d",
					$time, got.idx, got.fg, got.mask);
				return;
			end
			e = pending.pop_front();
			n_masks++;
			if (got.fg)
				n_fg++;
			if (got.idx !== e.idx) begin
				errors++;
				$display("%0t: out_index expected %0d actual %0d", $time, e.idx, got.idx);
			end
			if (got.fg !== e.fg) begin
				errors++;
				$display("%0t: foreground idx %0d expected %0d actual %0d",
					$time, e.idx, e.fg, got.fg);
			end
			if (got.mask !== e.mask) begin
				errors++;
				$display("%0t: mask_value idx %0d expected %0d actual %0d",
					$time, e.idx, e.mask, got.mask);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	avgbg_in_if  pin();
	avgbg_cfg_if cfg_bus();
	avgbg_out_if rout();

	average_background_subtractor u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pin),
		.cfg    (cfg_bus),
		.result (rout)
	);

	bg_scoreboard sb = new();

	pix_word_t stim_q[$];
	bit plan_prev[NUM_PIXELS];
	bit plan_lim[NUM_PIXELS];
	bit plan_first = 1;
	int plan_frames;
	logic [ADDR_W-1:0] pool[POOL_N];
	logic [CH_W-1:0] base[POOL_N][3];
	logic [ADDR_W-1:0] extra_idx[$];
	bit hold_req;
	int idle_cycles;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// acceptance monitor and watchdog
	always @(posedge clk) begin
		mask_word_t got;
		pix_word_t w;
		if (pin.valid && pin.ready) begin
			w.func = pin.func;
			w.idx = pin.pixel_index;
			w.px = {pin.blue, pin.green, pin.red};
			w.last = pin.last_of_frame;
			sb.note_word(w);
		end
		if (rout.valid && rout.ready) begin
			got.idx = rout.out_index;
			got.fg = rout.foreground;
			got.mask = rout.mask_value;
			sb.check_word(got);
		end
		if (cfg_bus.valid && cfg_bus.ready)
			sb.write_reg(cfg_bus.index, cfg_bus.data);
		if ((pin.valid && pin.ready) || (rout.valid && rout.ready) ||
			(cfg_bus.valid && cfg_bus.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: watchdog, no progress for %0d cycles", $time, IDLE_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// result side stalls, with a long hold-off on request
	initial begin : rx_side
		int cnt;
		int mode;
		cnt = 0;
		mode = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				rout.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 0;
			end else begin
				if (cnt == 0) begin
					mode = $urandom_range(0, 2);
					cnt = $urandom_range(16, 80);
				end
				cnt--;
				case (mode)
					0: rout.ready <= 1'b1;
					1: rout.ready <= $urandom_range(0, 1);
					default: rout.ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	function void add_word(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] i,
		logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b, logic l);
		pix_word_t w;
		if (f == FUNC_LEARN && plan_frames < MAX_LEARN_FRAMES) begin
			plan_prev[i] = 1;
			if (l) begin
				if (plan_first)
					plan_first = 0;
				else
					plan_frames++;
			end
		end
		if (f == FUNC_FINAL)
			plan_lim[i] = 1;
		w.func = f;
		w.idx = i;
		w.px = {b, g, r};
		w.last = l;
		stim_q.push_back(w);
	endfunction

	function logic [CH_W-1:0] jitter(logic [CH_W-1:0] v, int span);
		int x;
		x = int'(v) + $urandom_range(0, 2 * span) - span;
		if (x < 0)
			x = 0;
		if (x > 255)
			x = 255;
		return x[CH_W-1:0];
	endfunction

	task automatic send_all();
		int burst;
		pix_word_t w;
		burst = $urandom_range(1, 20);
		while (stim_q.size() > 0) begin
			w = stim_q.pop_front();
			if (burst == 0) begin
				@(negedge clk);
				pin.valid <= 1'b0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
				burst = $urandom_range(1, 24);
			end
			burst--;
			@(negedge clk);
			pin.valid <= 1'b1;
			pin.func <= w.func;
			pin.pixel_index <= w.idx;
			pin.red <= w.px[0];
			pin.green <= w.px[1];
			pin.blue <= w.px[2];
			pin.last_of_frame <= w.last;
			do
				@(posedge clk);
			while (!pin.ready);
		end
		@(negedge clk);
		pin.valid <= 1'b0;
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		while (sb.pending.size() > 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		// learn and finalize words leave no result, let them retire
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] i, logic [CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= i;
		cfg_bus.data <= d;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic learn_detect_phase(bit pressure);
		int k;
		int n;
		logic [ADDR_W-1:0] ix;
		logic [CH_W-1:0] v[3];
		for (int f = $urandom_range(2, 4); f > 0; f--) begin
			n = $urandom_range(1, 8);
			for (int j = 0; j < n; j++) begin
				k = $urandom_range(0, POOL_N - 1);
				for (int c = 0; c < 3; c++)
					v[c] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
						: jitter(base[k][c], $urandom_range(0, 40));
				if ($urandom_range(0, 9) == 0)
					add_word(FUNC_UNUSED, $urandom, $urandom, $urandom, $urandom,
						$urandom_range(0, 1));
				add_word(FUNC_LEARN, pool[k], v[0], v[1], v[2], j == n - 1);
			end
		end
		for (int k2 = 0; k2 < POOL_N; k2++)
			add_word(FUNC_FINAL, pool[k2], $urandom, $urandom, $urandom, $urandom_range(0, 1));
		for (int j = 0; j < 2; j++) begin
			ix = $urandom;
			extra_idx.push_back(ix);
			add_word(FUNC_FINAL, ix, $urandom, $urandom, $urandom, $urandom_range(0, 1));
		end
		send_all();
		if (pressure)
			hold_req = 1;
		for (int j = 0; j < 30; j++) begin
			k = $urandom_range(0, POOL_N - 1);
			if ($urandom_range(0, 4) == 0)
				ix = extra_idx[$urandom_range(0, extra_idx.size() - 1)];
			else
				ix = pool[k];
			for (int c = 0; c < 3; c++)
				v[c] = $urandom_range(0, 1) ? jitter(base[k][c], $urandom_range(0, 12))
					: $urandom_range(0, 255);
			add_word(FUNC_DETECT, ix, v[0], v[1], v[2], $urandom_range(0, 1));
		end
		send_all();
		drain();
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] hs_set[6];
		logic [CFG_DATA_W-1:0] ls_set[6];
		int tries;
		arst_n = 1'b0;
		hold_req = 0;
		idle_cycles = 0;
		pin.valid = 1'b0;
		pin.func = FUNC_LEARN;
		pin.pixel_index = '0;
		pin.red = '0;
		pin.green = '0;
		pin.blue = '0;
		pin.last_of_frame = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		rout.ready = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		pool = '{16'd0, 16'd1, 16'd2, 16'h5555, 16'hAAAA, 16'hFFFF};
		for (int k = 0; k < POOL_N; k++)
			for (int c = 0; c < 3; c++)
				base[k][c] = $urandom_range(0, 255);

		// directed: first frame only seeds the previous samples
		add_word(FUNC_LEARN, pool[0], 8'd0, 8'd0, 8'd0, 1'b0);
		add_word(FUNC_LEARN, pool[1], 8'd255, 8'd255, 8'd255, 1'b0);
		add_word(FUNC_LEARN, pool[2], 8'd0, 8'd255, 8'd0, 1'b0);
		add_word(FUNC_LEARN, pool[3], 8'h55, 8'h55, 8'h55, 1'b0);
		add_word(FUNC_LEARN, pool[4], 8'hAA, 8'hAA, 8'hAA, 1'b0);
		add_word(FUNC_LEARN, pool[5], 8'd128, 8'd1, 8'd254, 1'b1);
		// zero learned frames: thresholds come from the unit difference alone
		add_word(FUNC_FINAL, pool[0], 8'd0, 8'd0, 8'd0, 1'b0);
		add_word(FUNC_DETECT, pool[0], 8'd7, 8'd0, 8'd0, 1'b0);
		add_word(FUNC_DETECT, pool[0], 8'd8, 8'd0, 8'd0, 1'b1);
		add_word(FUNC_DETECT, pool[0], 8'd0, 8'd0, 8'd255, 1'b0);
		add_word(FUNC_UNUSED, 16'h1234, 8'd255, 8'd255, 8'd255, 1'b1);
		add_word(FUNC_LEARN, pool[0], 8'd255, 8'd0, 8'd128, 1'b0);
		add_word(FUNC_LEARN, pool[1], 8'd0, 8'd255, 8'd0, 1'b0);
		add_word(FUNC_LEARN, pool[2], 8'd0, 8'd0, 8'd255, 1'b0);
		add_word(FUNC_LEARN, pool[3], 8'hAA, 8'h55, 8'h55, 1'b0);
		add_word(FUNC_LEARN, pool[4], 8'h55, 8'hAA, 8'hAA, 1'b0);
		add_word(FUNC_LEARN, pool[5], 8'd128, 8'd1, 8'd254, 1'b1);
		for (int k = 0; k < POOL_N; k++)
			add_word(FUNC_FINAL, pool[k], 8'd0, 8'd0, 8'd0, k == 2);
		add_word(FUNC_DETECT, pool[0], 8'd255, 8'd0, 8'd128, 1'b0);
		add_word(FUNC_DETECT, pool[1], 8'd0, 8'd255, 8'd0, 1'b0);
		add_word(FUNC_DETECT, pool[5], 8'd128, 8'd1, 8'd254, 1'b1);
		add_word(FUNC_DETECT, pool[3], 8'd0, 8'd255, 8'd0, 1'b0);
		send_all();
		drain();

		hs_set = '{8'd0, 8'd255, 8'd16, 8'd0, 8'd0, 8'd255};
		ls_set = '{8'd0, 8'd255, 8'd16, 8'd0, 8'd0, 8'd0};
		hs_set[3] = $urandom_range(0, 255);
		ls_set[3] = $urandom_range(0, 255);
		hs_set[4] = $urandom_range(0, 255);
		ls_set[4] = $urandom_range(0, 255);
		for (int p = 0; p < 6; p++) begin
			write_reg(REG_HIGH_SCALE, hs_set[p]);
			write_reg(REG_LOW_SCALE, ls_set[p]);
			if (p == 2) begin
				// unknown indexes must leave the scales alone
				write_reg(8'd2, $urandom);
				write_reg(8'd255, $urandom);
			end
			learn_detect_phase(p == 3);
		end

		// saturate the sums, then run the frame count to its limit
		write_reg(REG_HIGH_SCALE, $urandom_range(0, 255));
		write_reg(REG_LOW_SCALE, $urandom_range(0, 255));
		for (int j = 0; j < 20; j++)
			add_word(FUNC_LEARN, pool[1], 8'd255, j[0] ? 8'd255 : 8'd0, $urandom, 1'b0);
		tries = 0;
		while (plan_frames < MAX_LEARN_FRAMES) begin
			add_word(FUNC_LEARN, pool[1], 8'd255, tries[0] ? 8'd255 : 8'd0, $urandom, 1'b1);
			tries++;
		end
		// learning is closed now, any index is dropped
		for (int j = 0; j < 5; j++)
			add_word(FUNC_LEARN, $urandom, $urandom, $urandom, $urandom, 1'b1);
		for (int k = 0; k < POOL_N; k++)
			add_word(FUNC_FINAL, pool[k], $urandom, $urandom, $urandom, 1'b0);
		for (int j = 0; j < 24; j++)
			add_word(FUNC_DETECT, pool[j % POOL_N], $urandom, $urandom, $urandom,
				$urandom_range(0, 1));
		send_all();
		drain();

		tries = 0;
		while (sb.pending.size() > 0 && tries < 5000) begin
			@(posedge clk);
			tries++;
		end
		if (sb.pending.size() > 0) begin
			sb.errors += sb.pending.size();
			$display("%0t: %0d mask words never arrived", $time, sb.pending.size());
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("run: %0d pixel words, %0d mask words (%0d foreground), %0d register writes",
			sb.n_words, sb.n_masks, sb.n_fg, sb.n_writes);
		$display("run: learned frame count reached %0d, with saturated sums and a long stall",
			sb.frames);
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
`default_nettype wire
